// ===== rtl/core/tsr_pkg.sv =====
// Shared types and constants for the trapezoid speed ramp.
// Holds the ramp phase encoding, phase output codes and configuration register indexes.
// No dependencies.
package tsr_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int INC_BITS       = 10;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_GOAL_SPEED_LEFT   = 3'd0;
    localparam t_cfg_index CFG_GOAL_SPEED_RIGHT  = 3'd1;
    localparam t_cfg_index CFG_TARGET_STEPS_LEFT = 3'd2;
    localparam t_cfg_index CFG_TARGET_STEPS_RIGHT = 3'd3;
    localparam t_cfg_index CFG_RAMP_LENGTH       = 3'd4;
    localparam t_cfg_index CFG_ACCEL_ENABLE      = 3'd5;
    localparam t_cfg_index CFG_SPEED_INCREMENT   = 3'd6;

    typedef logic [1:0] t_phase_code;

    localparam t_phase_code PHASE_CODE_ACCEL  = 2'd0;
    localparam t_phase_code PHASE_CODE_CRUISE = 2'd1;
    localparam t_phase_code PHASE_CODE_DECEL  = 2'd2;

    typedef enum logic [2:0] {
        PH_ACCEL  = 3'b001,
        PH_CRUISE = 3'b010,
        PH_DECEL  = 3'b100
    } t_phase;

endpackage

// ===== rtl/core/trapezoid_speed_ramp.sv =====
// Trapezoid speed ramp: two-wheel speed command generator, one transaction per timer tick.
// Depends on tsr_pkg (phase encoding, register indexes).
//
// channel  direction  handshake                  payload
// in       sink       i_in_valid / o_in_ready    i_action, i_step_count_left/right
// out      source     o_out_valid / i_out_ready  o_speed_left/right, o_speed_updated,
//                                                o_running, o_phase
// cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each transaction passes through the input register and then the result register;
// one transaction per cycle sustained while the output is not stalled.
// The speed update (accelerate add, then decelerate subtract) is the longest path.
// A stalled output holds the result register; the input register still takes one
// more transaction, then ready drops. Synchronous active-low reset clears state and
// restores configuration defaults (speed increment 1, all else 0).
module trapezoid_speed_ramp
    import tsr_pkg::*;
#(
    parameter int SPEED_BITS = 16,
    parameter int STEP_BITS  = 32,
    localparam int CFG_BITS  = (SPEED_BITS > STEP_BITS) ? SPEED_BITS : STEP_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic signed [STEP_BITS-1:0]  i_step_count_left,
    input  logic signed [STEP_BITS-1:0]  i_step_count_right,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SPEED_BITS-1:0] o_speed_left,
    output logic signed [SPEED_BITS-1:0] o_speed_right,
    output logic                         o_speed_updated,
    output logic                         o_running,
    output logic [1:0]                   o_phase
);

    localparam int SUM_BITS = ((SPEED_BITS > INC_BITS) ? SPEED_BITS : INC_BITS) + 2;

    localparam logic signed [SUM_BITS-1:0] SPD_MAX =
        {{(SUM_BITS-SPEED_BITS+1){1'b0}}, {(SPEED_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SPD_MIN =
        {{(SUM_BITS-SPEED_BITS+1){1'b1}}, {(SPEED_BITS-1){1'b0}}};

    function automatic logic [SPEED_BITS-1:0] speed_mag(input logic [SPEED_BITS-1:0] v);
        return v[SPEED_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [STEP_BITS-1:0] step_mag(input logic [STEP_BITS-1:0] v);
        return v[STEP_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // saturating speed +/- increment
    function automatic logic [SPEED_BITS-1:0] speed_step(
        input logic [SPEED_BITS-1:0] v,
        input logic [INC_BITS-1:0]   inc,
        input logic                  sub
    );
        logic signed [SUM_BITS-1:0] a;
        logic signed [SUM_BITS-1:0] b;
        logic signed [SUM_BITS-1:0] s;
        a = {{(SUM_BITS-SPEED_BITS){v[SPEED_BITS-1]}}, v};
        b = {{(SUM_BITS-INC_BITS){1'b0}}, inc};
        s = sub ? (a - b) : (a + b);
        if (s > SPD_MAX) begin
            s = SPD_MAX;
        end else if (s < SPD_MIN) begin
            s = SPD_MIN;
        end
        return s[SPEED_BITS-1:0];
    endfunction

    // configuration registers
    logic signed [SPEED_BITS-1:0] r_goal_left;
    logic signed [SPEED_BITS-1:0] r_goal_right;
    logic signed [STEP_BITS-1:0]  r_target_left;
    logic signed [STEP_BITS-1:0]  r_target_right;
    logic [STEP_BITS-2:0]         r_ramp_length;
    logic                         r_accel_enable;
    logic [INC_BITS-1:0]          r_speed_inc;

    // values derived from configuration, refreshed every cycle
    logic [SPEED_BITS-1:0]        r_goal_mag_left;
    logic [SPEED_BITS-1:0]        r_goal_mag_right;
    logic [STEP_BITS-1:0]         r_tgt_mag_left;
    logic [STEP_BITS-1:0]         r_tgt_mag_right;
    logic [STEP_BITS:0]           r_thr_left;
    logic [STEP_BITS:0]           r_thr_right;

    // input register
    logic                         r_in_valid;
    logic                         r_in_action;
    logic [STEP_BITS-1:0]         r_mag_left;
    logic [STEP_BITS-1:0]         r_mag_right;

    // ramp state
    logic [SPEED_BITS-1:0]        r_spd_left;
    logic [SPEED_BITS-1:0]        r_spd_right;
    t_phase                       r_phase;
    logic                         r_running;

    // result register
    logic                         r_out_valid;
    logic [SPEED_BITS-1:0]        r_out_left;
    logic [SPEED_BITS-1:0]        r_out_right;
    logic                         r_out_updated;
    logic                         r_out_running;
    t_phase_code                  r_out_phase;

    logic                         fire;
    logic                         in_take;
    logic [SPEED_BITS-1:0]        n_spd_left;
    logic [SPEED_BITS-1:0]        n_spd_right;
    t_phase                       n_phase;
    logic                         n_running;
    logic                         n_updated;
    t_phase_code                  n_phase_code;
    logic                         near_left;
    logic                         near_right;

    assign o_cfg_ready = 1'b1;
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign in_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_left    <= '0;
            r_goal_right   <= '0;
            r_target_left  <= '0;
            r_target_right <= '0;
            r_ramp_length  <= '0;
            r_accel_enable <= 1'b0;
            r_speed_inc    <= {{(INC_BITS-1){1'b0}}, 1'b1};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GOAL_SPEED_LEFT:    r_goal_left    <= i_cfg_data[SPEED_BITS-1:0];
                CFG_GOAL_SPEED_RIGHT:   r_goal_right   <= i_cfg_data[SPEED_BITS-1:0];
                CFG_TARGET_STEPS_LEFT:  r_target_left  <= i_cfg_data[STEP_BITS-1:0];
                CFG_TARGET_STEPS_RIGHT: r_target_right <= i_cfg_data[STEP_BITS-1:0];
                CFG_RAMP_LENGTH:        r_ramp_length  <= i_cfg_data[STEP_BITS-2:0];
                CFG_ACCEL_ENABLE:       r_accel_enable <= i_cfg_data[0];
                CFG_SPEED_INCREMENT:    r_speed_inc    <= i_cfg_data[INC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // magnitudes and deceleration thresholds; thr is signed, negative means always near
    always_ff @(posedge i_clk) begin
        r_goal_mag_left  <= speed_mag(r_goal_left);
        r_goal_mag_right <= speed_mag(r_goal_right);
        r_tgt_mag_left   <= step_mag(r_target_left);
        r_tgt_mag_right  <= step_mag(r_target_right);
        r_thr_left       <= {1'b0, step_mag(r_target_left)} - {2'b00, r_ramp_length};
        r_thr_right      <= {1'b0, step_mag(r_target_right)} - {2'b00, r_ramp_length};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_action;
            r_mag_left  <= step_mag(i_step_count_left);
            r_mag_right <= step_mag(i_step_count_right);
        end
    end

    assign near_left  = r_thr_left[STEP_BITS]  || (r_mag_left  >= r_thr_left[STEP_BITS-1:0]);
    assign near_right = r_thr_right[STEP_BITS] || (r_mag_right >= r_thr_right[STEP_BITS-1:0]);

    always_comb begin
        n_spd_left  = r_spd_left;
        n_spd_right = r_spd_right;
        n_phase     = r_phase;
        n_running   = r_running;
        n_updated   = 1'b0;
        if (r_in_action) begin
            n_spd_left  = '0;
            n_spd_right = '0;
            n_phase     = PH_ACCEL;
            n_running   = 1'b1;
            n_updated   = 1'b1;
        end else if (r_accel_enable) begin
            if (r_phase == PH_ACCEL) begin
                if (speed_mag(r_spd_left) <= r_goal_mag_left &&
                    speed_mag(r_spd_right) <= r_goal_mag_right) begin
                    n_spd_left  = speed_step(r_spd_left, r_speed_inc, 1'b0);
                    n_spd_right = speed_step(r_spd_right, r_speed_inc, 1'b0);
                    n_updated   = 1'b1;
                end else begin
                    n_phase = PH_CRUISE;
                end
            end
            // decelerate test sees the speeds after any acceleration
            if (near_left && near_right &&
                $signed(n_spd_left) > 0 && $signed(n_spd_right) > 0) begin
                n_phase     = PH_DECEL;
                n_spd_left  = speed_step(n_spd_left, r_speed_inc, 1'b1);
                n_spd_right = speed_step(n_spd_right, r_speed_inc, 1'b1);
                n_updated   = 1'b1;
            end else if (n_phase == PH_DECEL) begin
                n_running = 1'b0;
            end
        end else begin
            n_running = !(r_mag_left >= r_tgt_mag_left && r_mag_right >= r_tgt_mag_right);
        end
    end

    always_comb begin
        case (n_phase)
            PH_ACCEL:  n_phase_code = PHASE_CODE_ACCEL;
            PH_CRUISE: n_phase_code = PHASE_CODE_CRUISE;
            PH_DECEL:  n_phase_code = PHASE_CODE_DECEL;
            default:   n_phase_code = PHASE_CODE_ACCEL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_left  <= '0;
            r_spd_right <= '0;
            r_phase     <= PH_ACCEL;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_spd_left  <= n_spd_left;
                r_spd_right <= n_spd_right;
                r_phase     <= n_phase;
                r_running   <= n_running;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_left    <= n_spd_left;
            r_out_right   <= n_spd_right;
            r_out_updated <= n_updated;
            r_out_running <= n_running;
            r_out_phase   <= n_phase_code;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_speed_left    = r_out_left;
    assign o_speed_right   = r_out_right;
    assign o_speed_updated = r_out_updated;
    assign o_running       = r_out_running;
    assign o_phase         = r_out_phase;

endmodule
